// ===== hdl/ssfr_pkg.sv =====
// Package: frame geometry, result type and tdata packing for the sync-sum frame receiver.
`default_nettype none
package ssfr_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned WORD_W      = 32;
    localparam int unsigned FRAME_LEN   = 19;
    localparam int unsigned STORE_LEN   = FRAME_LEN - 2;
    localparam int unsigned CNT_W       = 5;
    localparam int unsigned RES_BITS    = 4 * WORD_W + BYTE_W + 3;
    localparam int unsigned M_TDATA_W   = ((RES_BITS + 7) / 8) * 8;
    localparam logic [BYTE_W-1:0] SYNC_RESET = 8'hAA;

    localparam logic [CNT_W-1:0] CNT_IDLE = CNT_W'(0);
    localparam logic [CNT_W-1:0] CNT_SUM  = CNT_W'(FRAME_LEN - 1);

    localparam int unsigned FLAG_AT_POS = 0;
    localparam int unsigned FLAG_NET_UP = 2;
    localparam int unsigned FLAG_SHOT   = 4;

    typedef logic [BYTE_W-1:0] t_byte;

    typedef struct packed {
        logic        shot_request;
        logic        net_up;
        logic        at_position;
        t_byte       flag_byte;
        logic [WORD_W-1:0] word_d;
        logic [WORD_W-1:0] word_c;
        logic [WORD_W-1:0] word_b;
        logic [WORD_W-1:0] word_a;
    } t_result;

    function automatic logic [M_TDATA_W-1:0] pack_result(input t_result res);
        logic [M_TDATA_W-1:0] d;
        d = '0;
        d[RES_BITS-1:0] = res;
        return d;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/ssfr_frame_asm.sv =====
// Frame assembler: byte count, running sum, byte store and checksum check.
`default_nettype none
module ssfr_frame_asm (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire ssfr_pkg::t_byte i_sync_byte,
    input  wire                  i_byte_vld,
    input  wire ssfr_pkg::t_byte i_byte,
    output logic                 o_res_vld,
    output ssfr_pkg::t_result    o_res
);

    logic [ssfr_pkg::CNT_W-1:0] r_count, n_count;
    ssfr_pkg::t_byte            r_sum, n_sum;
    ssfr_pkg::t_byte            r_store [ssfr_pkg::STORE_LEN];
    logic                       store_shift;
    logic                       at_sum_pos;

    assign at_sum_pos = (r_count >= ssfr_pkg::CNT_SUM);

    always_comb begin
        n_count     = r_count;
        n_sum       = r_sum;
        store_shift = 1'b0;
        o_res_vld   = 1'b0;
        if (i_byte_vld) begin
            priority if (r_count == ssfr_pkg::CNT_IDLE) begin
                // hunt for the start byte
                if (i_byte == i_sync_byte) begin
                    n_count = ssfr_pkg::CNT_W'(1);
                    n_sum   = i_byte;
                end
            end else if (!at_sum_pos) begin
                store_shift = 1'b1;
                n_sum       = r_sum + i_byte;
                n_count     = r_count + ssfr_pkg::CNT_W'(1);
            end else begin
                n_count   = ssfr_pkg::CNT_IDLE;
                o_res_vld = (r_sum == i_byte);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= ssfr_pkg::CNT_IDLE;
            r_sum   <= '0;
        end else begin
            r_count <= n_count;
            r_sum   <= n_sum;
        end
    end

    // Exactly 17 data bytes shift in per frame, so entry 0 ends up holding byte 1.
    always_ff @(posedge i_clk) begin
        if (store_shift) begin
            for (int i = 0; i < ssfr_pkg::STORE_LEN - 1; i++) begin
                r_store[i] <= r_store[i+1];
            end
            r_store[ssfr_pkg::STORE_LEN-1] <= i_byte;
        end
    end

    always_comb begin
        o_res.word_a       = {r_store[3],  r_store[2],  r_store[1],  r_store[0]};
        o_res.word_b       = {r_store[7],  r_store[6],  r_store[5],  r_store[4]};
        o_res.word_c       = {r_store[11], r_store[10], r_store[9],  r_store[8]};
        o_res.word_d       = {r_store[15], r_store[14], r_store[13], r_store[12]};
        o_res.flag_byte    = r_store[16];
        o_res.at_position  = r_store[16][ssfr_pkg::FLAG_AT_POS];
        o_res.net_up       = r_store[16][ssfr_pkg::FLAG_NET_UP];
        o_res.shot_request = r_store[16][ssfr_pkg::FLAG_SHOT];
    end

endmodule
`default_nettype wire

// ===== hdl/ssfr_out_reg.sv =====
// Result register: holds one finished frame until the downstream side takes it.
`default_nettype none
module ssfr_out_reg (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_res_vld,
    input  wire ssfr_pkg::t_result i_res,
    input  wire                  i_take,
    output logic                 o_free,
    output logic                 o_vld,
    output ssfr_pkg::t_result    o_res
);

    logic              r_vld;
    ssfr_pkg::t_result r_res;

    // free when empty or being emptied this cycle
    assign o_free = !r_vld || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_free) begin
            r_vld <= i_res_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_res_vld) begin
            r_res <= i_res;
        end
    end

    assign o_vld = r_vld;
    assign o_res = r_res;

endmodule
`default_nettype wire

// ===== hdl/sync_sum_frame_receiver_unit.sv =====
// A good frame is registered and appears on the master side in the cycle after its checksum byte.
// Throughput: one received byte per cycle while the result register is free.
// Frames are 19 bytes; at most one request per frame leaves on the master side.
// Reset (synchronous, active low) clears the byte count, the sum and the result
// valid, and sets the sync byte to 0xAA; the byte store is not cleared.
`default_nettype none
module sync_sum_frame_receiver_unit (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_wr_en,
    input  wire [ssfr_pkg::BYTE_W-1:0]     i_cfg_wr_data,   // sync_byte
    input  wire                            s_axis_tvalid,
    output logic                           s_axis_tready,
    input  wire [ssfr_pkg::BYTE_W-1:0]     s_axis_tdata,    // [7:0] rx_byte
    output logic                           m_axis_tvalid,
    input  wire                            m_axis_tready,
    // [31:0] word_a, [63:32] word_b, [95:64] word_c, [127:96] word_d,
    // [135:128] flag_byte, [136] at_position, [137] net_up, [138] shot_request
    output logic [ssfr_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    ssfr_pkg::t_byte   r_sync;
    logic              byte_acc;
    logic              res_vld;
    ssfr_pkg::t_result res;
    ssfr_pkg::t_result out_res;
    logic              out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync <= ssfr_pkg::SYNC_RESET;
        end else if (i_cfg_wr_en) begin
            r_sync <= i_cfg_wr_data;
        end
    end

    assign s_axis_tready = out_free;
    assign byte_acc      = s_axis_tvalid && s_axis_tready;

    ssfr_frame_asm u_asm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sync_byte (r_sync),
        .i_byte_vld  (byte_acc),
        .i_byte      (s_axis_tdata),
        .o_res_vld   (res_vld),
        .o_res       (res)
    );

    ssfr_out_reg u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_res_vld (res_vld),
        .i_res     (res),
        .i_take    (m_axis_tready),
        .o_free    (out_free),
        .o_vld     (m_axis_tvalid),
        .o_res     (out_res)
    );

    assign m_axis_tdata = ssfr_pkg::pack_result(out_res);

    a_res_needs_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_vld |-> byte_acc)
        else $error("result raised without an accepted byte");

    a_new_out_from_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !$past(m_axis_tvalid)) |-> $past(byte_acc))
        else $error("result appeared without an accepted byte");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled while result register free");

    a_flag_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (out_res.net_up == out_res.flag_byte[ssfr_pkg::FLAG_NET_UP]
                           && out_res.shot_request == out_res.flag_byte[ssfr_pkg::FLAG_SHOT]))
        else $error("flag bits disagree with flag byte");

endmodule
`default_nettype wire
